### hdl/positional_process_list_core_macros.svh
// Assertion helpers shared by the list core modules.
// Every property samples on clk and is switched off while rst_n is low.
`ifndef POSITIONAL_PROCESS_LIST_CORE_MACROS_SVH
`define POSITIONAL_PROCESS_LIST_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ppl_pkg.sv
package ppl_pkg;

  // Default number of entries in the list store.
  localparam int unsigned LIST_DEPTH_DEF = 64;

  // Fixed field widths of the transfer payloads.
  localparam int unsigned FUNC_W = 4;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned PID_W  = 16;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 7;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd1;
  localparam logic [FUNC_W-1:0] FN_INSERT     = 4'd2;
  localparam logic [FUNC_W-1:0] FN_READ       = 4'd3;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd4;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd5;
  localparam logic [FUNC_W-1:0] FN_POP_AT     = 4'd6;
  localparam logic [FUNC_W-1:0] FN_FIND       = 4'd7;
  localparam logic [FUNC_W-1:0] FN_DELETE     = 4'd8;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

  // One command.
  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic [PID_W-1:0]         pid;
    logic signed [PRIO_W-1:0] priority_req;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [PID_W-1:0]         out_pid;
    logic signed [PRIO_W-1:0] out_priority;
    logic [CNT_W-1:0]         count;
  } out_item_t;

  // One stored list entry.
  typedef struct packed {
    logic [PID_W-1:0]         pid;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // Port enables from the sequencer to the entry memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

### hdl/ppl_mem.sv
module ppl_mem #(
  parameter int unsigned LIST_DEPTH = ppl_pkg::LIST_DEPTH_DEF,
  localparam int unsigned AW = $clog2(LIST_DEPTH)
) (
  input  logic              clk,
  input  ppl_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     waddr,
  input  ppl_pkg::entry_t   wdata,
  input  logic [AW-1:0]     raddr,
  output ppl_pkg::entry_t   rdata
);

  ppl_pkg::entry_t store_r [LIST_DEPTH];
  ppl_pkg::entry_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      store_r[waddr] <= wdata;
    end
  end

  // Registered read port; rdata follows in the cycle after rd_en.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= store_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/ppl_ctrl.sv
`include "positional_process_list_core_macros.svh"

module ppl_ctrl #(
  parameter int unsigned LIST_DEPTH = ppl_pkg::LIST_DEPTH_DEF,
  localparam int unsigned AW = $clog2(LIST_DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ppl_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_valid,
  output ppl_pkg::out_item_t out_result,
  output ppl_pkg::mem_ctl_t  mem_ctl,
  output logic [AW-1:0]      mem_waddr,
  output ppl_pkg::entry_t    mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  ppl_pkg::entry_t    mem_rdata
);

  localparam int unsigned CW   = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CMPW = (CW > ppl_pkg::POS_W) ? CW : ppl_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_UP    = 3'b010,
    S_SWEEP = 3'b100
  } state_t;

  // Control state.
  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               more_r, more_nxt;
  logic               pend_r, pend_nxt;
  logic               found_r, found_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Working registers of the running operation.
  logic [AW-1:0]      rd_r, rd_nxt;
  logic [AW-1:0]      lo_r, lo_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic               by_pid_r, by_pid_nxt;
  logic               remove_r, remove_nxt;
  logic [ppl_pkg::PID_W-1:0] key_r, key_nxt;
  ppl_pkg::entry_t    new_r, new_nxt;
  ppl_pkg::entry_t    hit_r, hit_nxt;
  ppl_pkg::out_item_t out_r, out_nxt;

  // Builds a result item; the count is cut to the field width.
  function automatic ppl_pkg::out_item_t mk_result(
    input logic [ppl_pkg::STAT_W-1:0] st,
    input ppl_pkg::entry_t            e,
    input logic [CW-1:0]              c
  );
    ppl_pkg::out_item_t r;
    logic [CMPW-1:0]    cx;
    cx             = CMPW'(c);
    r.status       = st;
    r.out_pid      = e.pid;
    r.out_priority = e.prio;
    r.count        = cx[ppl_pkg::CNT_W-1:0];
    return r;
  endfunction

  // Sequencer: decode in idle, then shift entries up or sweep forward.
  always_comb begin
    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic [CMPW-1:0] tgt_x;
    logic [CW-1:0]   cnt_inc;
    logic [CW-1:0]   cnt_dec;
    logic            full;
    logic            empty;
    logic            go_sweep;
    logic [AW-1:0]   sw_start;
    logic            match;

    pos_x    = CMPW'(in_item.position);
    cnt_x    = CMPW'(count_r);
    cnt_inc  = count_r + CW'(1);
    cnt_dec  = count_r - CW'(1);
    full     = (count_r == CW'(LIST_DEPTH));
    empty    = (count_r == '0);
    go_sweep = 1'b0;
    sw_start = '0;
    tgt_x    = '0;
    match    = 1'b0;

    state_nxt     = state_r;
    count_nxt     = count_r;
    more_nxt      = more_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    out_valid_nxt = 1'b0;
    rd_nxt        = rd_r;
    lo_nxt        = lo_r;
    idx_nxt       = idx_r;
    by_pid_nxt    = by_pid_r;
    remove_nxt    = remove_r;
    key_nxt       = key_r;
    new_nxt       = new_r;
    hit_nxt       = hit_r;
    out_nxt       = out_r;

    mem_ctl   = '0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_item.func)
            ppl_pkg::FN_PUSH_FRONT, ppl_pkg::FN_PUSH_BACK, ppl_pkg::FN_INSERT: begin
              if (in_item.func == ppl_pkg::FN_PUSH_FRONT) begin
                tgt_x = '0;
              end else if (in_item.func == ppl_pkg::FN_PUSH_BACK) begin
                tgt_x = cnt_x;
              end else begin
                tgt_x = pos_x;
              end
              if (in_item.func == ppl_pkg::FN_INSERT && pos_x > cnt_x) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_result(ppl_pkg::ST_BAD, '0, count_r);
              end else if (full) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_result(ppl_pkg::ST_FULL, '0, count_r);
              end else if (tgt_x == cnt_x) begin
                // Append at the back: nothing moves.
                mem_ctl.wr_en  = 1'b1;
                mem_waddr      = count_r[AW-1:0];
                mem_wdata.pid  = in_item.pid;
                mem_wdata.prio = in_item.priority_req;
                count_nxt      = cnt_inc;
                out_valid_nxt  = 1'b1;
                out_nxt        = mk_result(ppl_pkg::ST_OK, '0, cnt_inc);
              end else begin
                state_nxt    = S_UP;
                rd_nxt       = cnt_dec[AW-1:0];
                lo_nxt       = tgt_x[AW-1:0];
                more_nxt     = 1'b1;
                pend_nxt     = 1'b0;
                new_nxt.pid  = in_item.pid;
                new_nxt.prio = in_item.priority_req;
              end
            end
            ppl_pkg::FN_READ, ppl_pkg::FN_POP_AT: begin
              if (pos_x >= cnt_x) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_result(ppl_pkg::ST_BAD, '0, count_r);
              end else begin
                go_sweep   = 1'b1;
                sw_start   = pos_x[AW-1:0];
                by_pid_nxt = 1'b0;
                remove_nxt = (in_item.func == ppl_pkg::FN_POP_AT);
              end
            end
            ppl_pkg::FN_POP_FRONT, ppl_pkg::FN_POP_BACK: begin
              if (empty) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_result(ppl_pkg::ST_BAD, '0, count_r);
              end else begin
                go_sweep   = 1'b1;
                sw_start   = (in_item.func == ppl_pkg::FN_POP_FRONT) ? '0
                                                                     : cnt_dec[AW-1:0];
                by_pid_nxt = 1'b0;
                remove_nxt = 1'b1;
              end
            end
            ppl_pkg::FN_FIND, ppl_pkg::FN_DELETE: begin
              if (empty) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_result(ppl_pkg::ST_MISSING, '0, count_r);
              end else begin
                go_sweep   = 1'b1;
                sw_start   = '0;
                by_pid_nxt = 1'b1;
                remove_nxt = (in_item.func == ppl_pkg::FN_DELETE);
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = mk_result(ppl_pkg::ST_BAD, '0, count_r);
            end
          endcase
          if (go_sweep) begin
            state_nxt = S_SWEEP;
            rd_nxt    = sw_start;
            more_nxt  = 1'b1;
            pend_nxt  = 1'b0;
            found_nxt = 1'b0;
            key_nxt   = in_item.pid;
          end
        end
      end

      S_UP: begin
        // Data read last cycle moves one place toward the back.
        if (pend_r) begin
          mem_ctl.wr_en = 1'b1;
          mem_waddr     = idx_r + AW'(1);
          mem_wdata     = mem_rdata;
        end
        // Read from the back down to the insert position.
        pend_nxt = more_r;
        if (more_r) begin
          mem_ctl.rd_en = 1'b1;
          mem_raddr     = rd_r;
          idx_nxt       = rd_r;
          if (rd_r == lo_r) begin
            more_nxt = 1'b0;
          end else begin
            rd_nxt = rd_r - AW'(1);
          end
        end
        // Gap is open: place the new entry.
        if (!more_r && !pend_r) begin
          mem_ctl.wr_en = 1'b1;
          mem_waddr     = lo_r;
          mem_wdata     = new_r;
          count_nxt     = cnt_inc;
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt       = mk_result(ppl_pkg::ST_OK, '0, cnt_inc);
        end
      end

      S_SWEEP: begin
        // Read forward up to the last entry.
        pend_nxt = more_r;
        if (more_r) begin
          mem_ctl.rd_en = 1'b1;
          mem_raddr     = rd_r;
          idx_nxt       = rd_r;
          if (rd_r == cnt_dec[AW-1:0]) begin
            more_nxt = 1'b0;
          end else begin
            rd_nxt = rd_r + AW'(1);
          end
        end
        // Check returned data; after a removal hit, close the gap.
        if (pend_r) begin
          if (!found_r) begin
            match = !by_pid_r || (mem_rdata.pid == key_r);
            if (match) begin
              found_nxt = 1'b1;
              hit_nxt   = mem_rdata;
              if (!remove_r) begin
                state_nxt     = S_IDLE;
                more_nxt      = 1'b0;
                pend_nxt      = 1'b0;
                out_valid_nxt = 1'b1;
                out_nxt       = mk_result(ppl_pkg::ST_OK, mem_rdata, count_r);
              end
            end
          end else if (remove_r) begin
            mem_ctl.wr_en = 1'b1;
            mem_waddr     = idx_r - AW'(1);
            mem_wdata     = mem_rdata;
          end
        end
        // All entries handled.
        if (!more_r && !pend_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (found_r) begin
            count_nxt = cnt_dec;
            out_nxt   = mk_result(ppl_pkg::ST_OK, hit_r, cnt_dec);
          end else begin
            out_nxt = mk_result(ppl_pkg::ST_MISSING, '0, count_r);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      more_r      <= 1'b0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      more_r      <= more_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    rd_r     <= rd_nxt;
    lo_r     <= lo_nxt;
    idx_r    <= idx_nxt;
    by_pid_r <= by_pid_nxt;
    remove_r <= remove_nxt;
    key_r    <= key_nxt;
    new_r    <= new_nxt;
    hit_r    <= hit_nxt;
    out_r    <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // A shift never writes the entry it reads in the same cycle.
  `PPL_ASSERT_SAME(a_no_rw_clash, mem_ctl.wr_en && mem_ctl.rd_en, mem_waddr != mem_raddr,
    "memory read and write hit the same entry")
  // Results are only shown once the sequencer is back in idle.
  `PPL_ASSERT_SAME(a_result_idle, out_valid_r, state_r == S_IDLE,
    "result strobe while an operation is still running")
  // An accepted command either answers at once or keeps the block busy.
  `PPL_ASSERT_NEXT(a_accept_progress, start && !busy, out_valid_r || busy,
    "accepted command neither answered nor started")
  // The entry count only changes together with a result.
  `PPL_ASSERT_NEXT(a_count_hold, !out_valid_nxt, $stable(count_r),
    "entry count changed without a result")
  // A full status is only given when the store is really full.
  `PPL_ASSERT_SAME(a_full_status, out_valid_r && out_r.status == ppl_pkg::ST_FULL,
    count_r == CW'(LIST_DEPTH), "full status with free entries")

endmodule

### hdl/positional_process_list_core.sv
// Errors and any push or insert at the back answer in the cycle after the transfer.
// Other pushes and inserts shift the later entries up first, one memory shift per cycle.
// Reads, pops, finds and deletes sweep the entry memory from the start position, one entry per
// cycle; pops and deletes run to the back, reads and finds stop at the first hit.
// One command at a time; errors and appends at the back never raise busy, others drop it in the
// result cycle. Reset clears control state and count, not memory; out_valid cannot be stalled.
module positional_process_list_core #(
  parameter int unsigned LIST_DEPTH = ppl_pkg::LIST_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ppl_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_valid,
  output ppl_pkg::out_item_t out_result
);

  localparam int unsigned AW = $clog2(LIST_DEPTH);

  ppl_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  ppl_pkg::entry_t   mem_wdata;
  ppl_pkg::entry_t   mem_rdata;

  // Sequencer with decode, shift and sweep control.
  ppl_ctrl #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_result(out_result),
    .mem_ctl   (mem_ctl),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Entry memory holding pid and priority per list position.
  ppl_mem #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_mem (
    .clk  (clk),
    .ctl  (mem_ctl),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

### sim/positional_process_list_core_tb.sv
module positional_process_list_core_tb;
  import ppl_pkg::*;

  localparam int unsigned LIST_DEPTH = LIST_DEPTH_DEF;
  localparam int unsigned RANDOM_CMDS = 950;
  localparam int unsigned PID_POOL_SIZE = 8;

  // Codes past the last operation; the block must answer them with a bad status.
  localparam logic [FUNC_W-1:0] FN_FIRST_UNUSED = FN_DELETE + 4'd1;
  localparam logic [FUNC_W-1:0] FN_LAST_UNUSED = '1;

  // Stimulus modes of the random part.
  localparam int unsigned MODE_GROW = 0;
  localparam int unsigned MODE_MIXED = 1;
  localparam int unsigned MODE_SHRINK = 2;

  // One row of the directed table: a command and, where pinned, its known answer.
  typedef struct packed {
    in_item_t  cmd;
    logic      pinned;
    out_item_t want;
  } step_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_result;

  // Shadow copy of the list, updated at every accepted command transfer.
  entry_t      list_mem [LIST_DEPTH];
  int unsigned list_len = 0;
  out_item_t   pending_results [$];
  logic [PID_W-1:0] pid_pool [PID_POOL_SIZE];

  int unsigned fails = 0;
  int unsigned results_checked = 0;
  int unsigned cmds_sent = 0;
  int unsigned peak_len = 0;
  int unsigned full_refusals = 0;
  int unsigned misses = 0;

  positional_process_list_core #(
    .LIST_DEPTH(LIST_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  always #6 clk = ~clk;

  // Open a gap at pos and write the new entry there.
  function automatic void list_place(input int unsigned pos, input in_item_t c);
    int unsigned i;
    for (i = list_len; i > pos; i--) begin
      list_mem[i] = list_mem[i - 1];
    end
    list_mem[pos].pid = c.pid;
    list_mem[pos].prio = c.priority_req;
    list_len++;
  endfunction

  // Remove the entry at pos and close the gap behind it.
  function automatic void list_take(input int unsigned pos, output entry_t e);
    int unsigned i;
    e = list_mem[pos];
    for (i = pos; i + 1 < list_len; i++) begin
      list_mem[i] = list_mem[i + 1];
    end
    list_len--;
  endfunction

  // Carry out one command on the shadow list and return the answer it should give.
  function automatic out_item_t apply_cmd(input in_item_t c);
    out_item_t   r;
    entry_t      taken;
    int unsigned hit;
    int unsigned i;
    logic        full;
    r = '0;
    taken = '0;
    hit = LIST_DEPTH;
    full = (list_len >= LIST_DEPTH);
    case (c.func)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (full) r.status = ST_FULL;
        else list_place((c.func == FN_PUSH_FRONT) ? 0 : list_len, c);
      end
      FN_INSERT: begin
        if (c.position > list_len) r.status = ST_BAD;
        else if (full) r.status = ST_FULL;
        else list_place(c.position, c);
      end
      FN_READ: begin
        if (c.position >= list_len) r.status = ST_BAD;
        else taken = list_mem[c.position];
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        if (list_len == 0) r.status = ST_BAD;
        else list_take((c.func == FN_POP_FRONT) ? 0 : list_len - 1, taken);
      end
      FN_POP_AT: begin
        if (c.position >= list_len) r.status = ST_BAD;
        else list_take(c.position, taken);
      end
      FN_FIND, FN_DELETE: begin
        // Scanning from the back means the last hit is the one nearest the front.
        for (i = list_len; i > 0; i--) begin
          if (list_mem[i - 1].pid == c.pid) hit = i - 1;
        end
        if (hit == LIST_DEPTH) r.status = ST_MISSING;
        else if (c.func == FN_FIND) taken = list_mem[hit];
        else list_take(hit, taken);
      end
      default: begin
        r.status = ST_BAD;
      end
    endcase
    r.out_pid = taken.pid;
    r.out_priority = taken.prio;
    r.count = CNT_W'(list_len);
    return r;
  endfunction

  function automatic in_item_t mk(input logic [FUNC_W-1:0] f, input int pos,
                                  input logic [PID_W-1:0] p, input int pr);
    in_item_t c;
    c.func = f;
    c.position = POS_W'(pos);
    c.pid = p;
    c.priority_req = PRIO_W'(pr);
    return c;
  endfunction

  function automatic out_item_t res(input logic [STAT_W-1:0] st, input int p, input int pr,
                                    input int cnt);
    out_item_t r;
    r.status = st;
    r.out_pid = PID_W'(p);
    r.out_priority = PRIO_W'(pr);
    r.count = CNT_W'(cnt);
    return r;
  endfunction

  // Draw a random command. The mode tilts the mix toward growing or draining the list.
  function automatic in_item_t pick_cmd(input int unsigned mode);
    in_item_t    c;
    int unsigned grow_pct;
    int unsigned shrink_pct;
    int unsigned roll;
    grow_pct = (mode == MODE_GROW) ? 92 : (mode == MODE_SHRINK) ? 0 : 40;
    shrink_pct = (mode == MODE_SHRINK) ? 92 : (mode == MODE_GROW) ? 0 : 40;
    c.priority_req = PRIO_W'($urandom);
    if ($urandom_range(0, 3) == 0) c.pid = PID_W'($urandom);
    else c.pid = pid_pool[$urandom_range(0, PID_POOL_SIZE - 1)];
    // Searches should mostly hit, so half of all commands on a non-empty list take a pid already held.
    if (list_len != 0 && $urandom_range(0, 1) == 1) begin
      c.pid = list_mem[$urandom_range(0, list_len - 1)].pid;
    end
    c.position = (list_len == 0) ? '0 : POS_W'($urandom_range(0, list_len - 1));
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) begin
      c.func = FUNC_W'($urandom_range(FN_FIRST_UNUSED, FN_LAST_UNUSED));
    end else if (roll < grow_pct) begin
      case ($urandom_range(0, 2))
        0: c.func = FN_PUSH_FRONT;
        1: c.func = FN_PUSH_BACK;
        default: begin
          c.func = FN_INSERT;
          c.position = POS_W'($urandom_range(0, list_len));
        end
      endcase
    end else if (roll < grow_pct + shrink_pct) begin
      case ($urandom_range(0, 3))
        0: c.func = FN_POP_FRONT;
        1: c.func = FN_POP_BACK;
        2: c.func = FN_POP_AT;
        default: c.func = FN_DELETE;
      endcase
    end else begin
      c.func = ($urandom_range(0, 1) == 1) ? FN_READ : FN_FIND;
    end
    // Now and then any position at all, to reach the bad-position paths.
    if ($urandom_range(0, 9) == 0) c.position = POS_W'($urandom);
    return c;
  endfunction

  // Hold the command on the inputs until the block takes it, then record its answer.
  task automatic issue(input in_item_t c, input logic pinned, input out_item_t want,
                       input int unsigned gap);
    out_item_t pred;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= c;
    do @(posedge clk); while (busy);
    pred = apply_cmd(c);
    pending_results.push_back(pinned ? want : pred);
    cmds_sent++;
    if (list_len > peak_len) peak_len = list_len;
    if (pred.status == ST_FULL) full_refusals++;
    if (pred.status == ST_MISSING) misses++;
  endtask

  // Every strobed result is checked against the oldest pending answer.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no command pending");
        fails++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_result.status);
          fails++;
        end
        if (out_result.out_pid !== want.out_pid) begin
          $error("out_pid: expected %h, got %h", want.out_pid, out_result.out_pid);
          fails++;
        end
        if (out_result.out_priority !== want.out_priority) begin
          $error("out_priority: expected %0d, got %0d", $signed(want.out_priority),
                 $signed(out_result.out_priority));
          fails++;
        end
        if (out_result.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_result.count);
          fails++;
        end
      end
    end
  end

  initial begin
    step_t       plan [$];
    int unsigned n;
    int unsigned gap;

    // Known answers on an empty list, then a small list built by hand.
    plan = '{
      '{mk(FN_POP_FRONT, 0, 16'h0000, 0), 1'b1, res(ST_BAD, 0, 0, 0)},
      '{mk(FN_POP_BACK, 127, 16'hffff, -1), 1'b1, res(ST_BAD, 0, 0, 0)},
      '{mk(FN_POP_AT, 0, 16'h0000, 0), 1'b1, res(ST_BAD, 0, 0, 0)},
      '{mk(FN_READ, 0, 16'h0000, 0), 1'b1, res(ST_BAD, 0, 0, 0)},
      '{mk(FN_FIND, 0, 16'h1234, 0), 1'b1, res(ST_MISSING, 0, 0, 0)},
      '{mk(FN_DELETE, 0, 16'hffff, 0), 1'b1, res(ST_MISSING, 0, 0, 0)},
      '{mk(FN_INSERT, 1, 16'h0001, 5), 1'b1, res(ST_BAD, 0, 0, 0)},
      '{mk(FN_FIRST_UNUSED, 0, 16'h0000, 0), 1'b1, res(ST_BAD, 0, 0, 0)},
      '{mk(FN_LAST_UNUSED, 127, 16'hffff, -1), 1'b1, res(ST_BAD, 0, 0, 0)},
      '{mk(FN_INSERT, 0, 16'hffff, 127), 1'b1, res(ST_OK, 0, 0, 1)},
      '{mk(FN_PUSH_FRONT, 127, 16'h0000, -128), 1'b1, res(ST_OK, 0, 0, 2)},
      '{mk(FN_PUSH_BACK, 64, 16'hffff, 0), 1'b1, res(ST_OK, 0, 0, 3)},
      '{mk(FN_INSERT, 3, 16'haaaa, -1), 1'b1, res(ST_OK, 0, 0, 4)},
      '{mk(FN_INSERT, 5, 16'h0002, 3), 1'b1, res(ST_BAD, 0, 0, 4)},
      '{mk(FN_INSERT, 1, 16'h5555, 1), 1'b0, '0},
      '{mk(FN_READ, 0, 16'h0000, 0), 1'b0, '0},
      '{mk(FN_FIND, 0, 16'hffff, 0), 1'b0, '0},
      '{mk(FN_DELETE, 0, 16'hffff, 0), 1'b0, '0},
      '{mk(FN_READ, 64, 16'h0000, 0), 1'b0, '0},
      '{mk(FN_POP_AT, 127, 16'h0000, 0), 1'b0, '0},
      '{mk(FN_POP_AT, 1, 16'h0000, 0), 1'b0, '0},
      '{mk(FN_POP_BACK, 0, 16'h0000, 0), 1'b0, '0},
      '{mk(FN_POP_FRONT, 0, 16'h0000, 0), 1'b0, '0},
      '{mk(FN_DELETE, 0, 16'h0000, 0), 1'b0, '0}
    };

    for (n = 0; n < PID_POOL_SIZE; n++) begin
      pid_pool[n] = PID_W'($urandom);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      issue(plan[i].cmd, plan[i].pinned, plan[i].want, $urandom_range(0, 9));
    end

    // Random part: the list is filled past full, stirred, drained past empty, and stirred, in repeated turns.
    for (n = 0; n < RANDOM_CMDS; n++) begin
      gap = ((n / 50) % 3 == 2) ? 0 : $urandom_range(0, 9);
      case ((n / 80) % 4)
        0: issue(pick_cmd(MODE_GROW), 1'b0, '0, gap);
        2: issue(pick_cmd(MODE_SHRINK), 1'b0, '0, gap);
        default: issue(pick_cmd(MODE_MIXED), 1'b0, '0, gap);
      endcase
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (LIST_DEPTH + 4) @(posedge clk);

    $display("Checked %0d results from %0d commands; list reached %0d of %0d entries.",
             results_checked, cmds_sent, peak_len, LIST_DEPTH);
    $display("Pushes refused on a full list: %0d; searches for a missing pid: %0d.",
             full_refusals, misses);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #6000000;
    $error("timeout waiting on the block");
    $display("status: fail");
    $finish;
  end

endmodule
